// ===== hdl/sha256_hash_with_precalc_assert.svh =====
// Assertion macros for the SHA-256 hasher.
// Included by the modules that carry concurrent checks.
`ifndef SHA256_HASH_WITH_PRECALC_ASSERT_SVH
`define SHA256_HASH_WITH_PRECALC_ASSERT_SVH
// check that an implication holds at every clock
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// check that a condition holds in the clock cycle after another
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/sha_pkg.sv =====
// Package for the SHA-256 hasher: round constants, sizes, register codes.
// No dependencies.
`default_nettype none
package sha_pkg;
  localparam int DIGEST_WORDS = 8;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT45 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT67 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRECALC = 3'd4;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef struct packed {
    logic start;     // pulse: load working words, run a block
    logic precalc;   // three rounds, no feed-forward
  } comp_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
      32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
      32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
      32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
      32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
    return k[t];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/sha_if.sv =====
// Valid/ready channel interfaces for the SHA-256 hasher.
// No dependencies.
`default_nettype none
interface sha_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic byte_present;
  logic end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [31:0] digest_word;
  logic last_word;
  modport source (output valid, digest_word, last_word, input ready);
  modport sink (input valid, digest_word, last_word, output ready);
endinterface
`default_nettype wire

// ===== hdl/sha_round.sv =====
// SHA-256 compression engine: one round per cycle on a shared round unit.
// Uses sha_pkg; the schedule is a 16-word ring held here.
`default_nettype none
module sha_round (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sha_pkg::comp_ctl_t ctl,
  input  wire logic [31:0] chain_in [8],
  input  wire logic [31:0] w_in,       // schedule word for rounds 0..15
  output logic [5:0] round,            // current round, block buffer word address
  output logic busy,
  output logic done,                   // one-cycle pulse, chain_out valid
  output logic [31:0] chain_out [8]
);
  import sha_pkg::*;
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic pc;
  logic [31:0] wt, t1, t2, w2, w15;
  logic last;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    w2 = w[round[3:0] - 4'd2];
    w15 = w[round[3:0] - 4'd15];
    if (round < 6'd16) begin
      wt = w_in;
    end else begin
      wt = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w[round[3:0] - 4'd7] +
           (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[round[3:0]];
    end
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
         (v[6] ^ (v[4] & (v[5] ^ v[6]))) + round_k(round) + wt;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
         ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
    last = pc ? (round == 6'd2) : (round == 6'd63);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      round <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      round <= '0;
      pc <= ctl.precalc;
      v <= chain_in;
    end else if (busy) begin
      w[round[3:0]] <= wt;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      round <= round + 6'd1;
      if (last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[i] = pc ? v[i] : chain_in[i] + v[i];
  end

  `include "sha256_hash_with_precalc_assert.svh"
  `SHA_ASSERT_NEXT(a_done_ends, clk, rst, done, !busy)
  `SHA_ASSERT_IMP(a_round_pc, clk, rst, busy && pc, round < 6'd3)
  `SHA_ASSERT_IMP(a_no_restart, clk, rst, busy, !ctl.start)
endmodule
`default_nettype wire

// ===== hdl/sha256_hash_with_precalc.sv =====
// Top level of the SHA-256 hasher with configurable start words.
// Uses sha_pkg, sha_if, sha_round and the assertion header.
`default_nettype none
// Message bytes arrive one item at a time; an item that completes a 64-byte
// block holds off further input while the block runs through the shared round
// unit at one round per cycle (64 rounds, or 3 in precalc mode); the unit is
// started first and the result is folded back before the next item is taken. An
// end-of-message item adds one or two padded blocks and then delivers the digest
// words, word zero first, at up to one per cycle. The block buffer is a 16-word
// memory read by the round unit one word per round. No input is taken while a
// block is compressing or the digest is being delivered. Configuration writes
// land in the word registers and take effect at the next message start.
module sha256_hash_with_precalc (
  input wire logic clk,
  input wire logic rst,
  sha_in_if.sink in_ch,
  sha_out_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [sha_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [sha_pkg::CFG_W-1:0] cfg_data
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IN   = 6'b000001,
    S_COMP = 6'b000010,
    S_PAD  = 6'b000100,
    S_LEN  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [63:0] init01, init23, init45, init67;
  logic precalc_cfg, precalc;
  logic idle;
  logic [63:0] byte_count;
  logic [31:0] buf_mem [16];
  logic [31:0] chain [8];
  logic ending;          // padding phase underway
  logic final_blk;       // block in flight is the last one
  logic [5:0] pos;       // padding write position
  logic [2:0] out_idx;
  comp_ctl_t ctl;
  logic [5:0] round;
  logic busy, done;
  logic [31:0] chain_out [8];
  logic [31:0] rd_word;
  logic [63:0] bits;
  logic take;

  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IN);
  assign bits = byte_count << 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      init01 <= 64'h6A09E667BB67AE85;
      init23 <= 64'h3C6EF372A54FF53A;
      init45 <= 64'h510E527F9B05688C;
      init67 <= 64'h1F83D9AB5BE0CD19;
      precalc_cfg <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT01: init01 <= cfg_data;
        REG_INIT23: init23 <= cfg_data;
        REG_INIT45: init45 <= cfg_data;
        REG_INIT67: init67 <= cfg_data;
        REG_PRECALC: precalc_cfg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // round unit reads the buffer word of its round, registered below; word 0 on start
  always_ff @(posedge clk) rd_word <= buf_mem[ctl.start ? 4'd0 : round[3:0] + 4'd1];

  function automatic logic [31:0] put_byte(input logic [31:0] wd, input logic [1:0] lane,
                                          input logic [7:0] b);
    logic [31:0] r;
    r = wd;
    r[8*(3-lane) +: 8] = b;
    return r;
  endfunction

  logic [31:0] hold;   // partially filled word

  always_ff @(posedge clk) begin
    ctl <= '0;
    if (rst) begin
      state <= S_IN;
      idle <= 1'b1;
      byte_count <= '0;
      ending <= 1'b0;
      final_blk <= 1'b0;
      out_idx <= '0;
    end else begin
      unique case (state)
        S_IN: if (take) begin
          logic [63:0] bc;
          logic [31:0] hw;
          bc = idle ? 64'd0 : byte_count;
          hw = (bc[1:0] == 2'd0) ? 32'd0 : hold;
          if (idle) begin
            chain[0] <= init01[63:32]; chain[1] <= init01[31:0];
            chain[2] <= init23[63:32]; chain[3] <= init23[31:0];
            chain[4] <= init45[63:32]; chain[5] <= init45[31:0];
            chain[6] <= init67[63:32]; chain[7] <= init67[31:0];
            precalc <= precalc_cfg;
            idle <= 1'b0;
          end
          if (in_ch.byte_present) begin
            hw = put_byte(hw, bc[1:0], in_ch.data_byte);
            buf_mem[bc[5:2]] <= hw;
            bc = bc + 64'd1;
          end
          byte_count <= bc;
          hold <= hw;
          pos <= bc[5:0];
          if (in_ch.byte_present && bc[5:0] == 6'd0) begin
            ctl <= '{start: 1'b1, precalc: idle ? precalc_cfg : precalc};
            ending <= in_ch.end_of_message;
            state <= S_COMP;
          end else if (in_ch.end_of_message) begin
            ending <= 1'b1;
            state <= S_PAD;
          end
        end
        S_COMP: if (done) begin
          chain <= chain_out;
          if (final_blk) begin
            final_blk <= 1'b0;
            out_idx <= '0;
            state <= S_OUT;
          end else if (ending) begin
            pos <= 6'd0;
            state <= S_PAD;
          end else begin
            state <= S_IN;
          end
        end
        S_PAD: begin
          // write the marker byte into the open word, zero the rest of it
          buf_mem[pos[5:2]] <= put_byte((pos[1:0] == 2'd0) ? 32'd0 : hold,
                                        pos[1:0], PAD_BYTE);
          pos <= {pos[5:2] + 4'd1, 2'b00};
          state <= S_LEN;
        end
        S_LEN: begin
          if (pos == 6'd0) begin
            // wrapped past 64: block is full, compress and pad another
            ctl <= '{start: 1'b1, precalc: precalc};
            state <= S_FIN;
          end else if (pos != LEN_POS) begin
            // zero fill; a marker in word 14 runs on through word 15 and wraps
            buf_mem[pos[5:2]] <= '0;
            pos <= {pos[5:2] + 4'd1, 2'b00};
          end else begin
            buf_mem[14] <= bits[63:32];
            buf_mem[15] <= bits[31:0];
            ctl <= '{start: 1'b1, precalc: precalc};
            final_blk <= 1'b1;
            state <= S_COMP;
          end
        end
        S_FIN: if (done) begin
          // marker went in the block just compressed; next block is zeros + length
          chain <= chain_out;
          buf_mem[0] <= '0;
          pos <= 6'd4;
          state <= S_LEN;
        end
        S_OUT: if (out_ch.ready) begin
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'(DIGEST_WORDS - 1)) begin
            idle <= 1'b1;
            ending <= 1'b0;
            state <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  sha_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .chain_in(chain), .w_in(rd_word),
    .round(round), .busy(busy), .done(done), .chain_out(chain_out)
  );

  assign out_ch.valid = (state == S_OUT);
  assign out_ch.digest_word = chain[out_idx];
  assign out_ch.last_word = (out_idx == 3'(DIGEST_WORDS - 1));

  `include "sha256_hash_with_precalc_assert.svh"
  `SHA_ASSERT_IMP(a_ready_only_in, clk, rst, busy, !in_ch.ready)
  `SHA_ASSERT_IMP(a_out_not_busy, clk, rst, out_ch.valid, !busy)
  `SHA_ASSERT_NEXT(a_start_busy, clk, rst, ctl.start, busy)
endmodule
`default_nettype wire
